>>> rtl/core/kdpd_pkg.sv
`timescale 1ns / 1ps

package kdpd_pkg;

  // Matrix geometry. Keys are numbered row * COLS + col in scan order.
  localparam int ROWS  = 4;
  localparam int COLS  = 4;
  localparam int NKEYS = ROWS * COLS;

  // Fixed widths of the transaction fields.
  localparam int KEY_BITS_W = 16;
  localparam int INDEX_W    = 4;
  localparam int LABEL_W    = 7;

  // Size of the printed label table.
  localparam int TABLE_ROWS = 4;
  localparam int TABLE_COLS = 4;

  localparam logic [LABEL_W-1:0] LABEL_NONE    = 7'h20;  // space
  localparam logic [LABEL_W-1:0] LABEL_UNKNOWN = 7'h3F;  // question mark

  typedef logic [LABEL_W-1:0] label_row_t [TABLE_COLS];

  localparam label_row_t LABEL_TABLE [TABLE_ROWS] = '{
    '{7'h31, 7'h32, 7'h33, 7'h41},  // 1 2 3 A
    '{7'h34, 7'h35, 7'h36, 7'h42},  // 4 5 6 B
    '{7'h37, 7'h38, 7'h39, 7'h43},  // 7 8 9 C
    '{7'h2A, 7'h30, 7'h23, 7'h44}   // * 0 # D
  };

  // Debounce level of one key.
  typedef enum logic [1:0] {
    LVL_RELEASED = 2'd0,
    LVL_MAYBE    = 2'd1,
    LVL_HELD     = 2'd2
  } level_t;

  // One poll result as it travels from the selector to the result register.
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic [LABEL_W-1:0] label;
  } press_t;

  function automatic logic [LABEL_W-1:0] label_of(input int r, input int c);
    logic [LABEL_W-1:0] lab;
    lab = LABEL_UNKNOWN;
    if (r < TABLE_ROWS && c < TABLE_COLS) begin
      lab = LABEL_TABLE[r[1:0]][c[1:0]];
    end
    return lab;
  endfunction

endpackage

>>> rtl/core/kdpd_level_bank.sv
`timescale 1ns / 1ps

module kdpd_level_bank (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             update,
  input  logic [kdpd_pkg::KEY_BITS_W-1:0]  key_bits,
  output logic [kdpd_pkg::NKEYS-1:0]       new_press
);
  import kdpd_pkg::*;

  level_t levels      [NKEYS];
  level_t levels_next [NKEYS];

  for (genvar k = 0; k < NKEYS; k++) begin : g_key
    logic high;

    // Keys past the sampled bits always read low.
    if (k < KEY_BITS_W) begin : g_sampled
      assign high = key_bits[k];
    end else begin : g_unsampled
      assign high = 1'b0;
    end

    // A key reports a press only on the step from maybe to held.
    assign new_press[k] = high && (levels[k] == LVL_MAYBE);

    always_comb begin
      case (levels[k])
        LVL_RELEASED: levels_next[k] = high ? LVL_MAYBE : LVL_RELEASED;
        LVL_MAYBE:    levels_next[k] = high ? LVL_HELD : LVL_RELEASED;
        LVL_HELD:     levels_next[k] = high ? LVL_HELD : LVL_MAYBE;
        default:      levels_next[k] = LVL_RELEASED;
      endcase
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        levels[k] <= LVL_RELEASED;
      end else if (update) begin
        levels[k] <= levels_next[k];
      end
    end
  end

endmodule

>>> rtl/core/kdpd_press_select.sv
`timescale 1ns / 1ps

module kdpd_press_select (
  input  logic [kdpd_pkg::NKEYS-1:0] new_press,
  output kdpd_pkg::press_t           press
);
  import kdpd_pkg::*;

  // Later keys in scan order override earlier ones.
  always_comb begin
    press.valid = 1'b0;
    press.index = '0;
    press.label = LABEL_NONE;
    for (int k = 0; k < NKEYS; k++) begin
      if (new_press[k]) begin
        press.valid = 1'b1;
        press.index = INDEX_W'(k);
        press.label = label_of(k / COLS, k % COLS);
      end
    end
  end

endmodule

>>> rtl/core/keypad_debounce_press_detect.sv
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------
// input    | in_valid / in_stall  | key_bits
// output   | out_valid / out_stall| press_valid, press_index, press_label
//
// One poll transaction can be accepted every cycle unless the input stalls.
// Its result transaction passes the input register and then the result
// register before it is offered.
// The debounce levels of all keys update together as a poll moves from the
// input register into the result register.
// Reset clears every key to released and empties both registers.
// When the output stalls, the input register still fills once, then the
// input stalls until the result transaction is taken.
module keypad_debounce_press_detect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kdpd_pkg::KEY_BITS_W-1:0]  key_bits,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             press_valid,
  output logic [kdpd_pkg::INDEX_W-1:0]     press_index,
  output logic [kdpd_pkg::LABEL_W-1:0]     press_label
);
  import kdpd_pkg::*;

  // Input register holding one poll.
  logic                  poll_valid;
  logic [KEY_BITS_W-1:0] poll_bits;

  // Result register.
  press_t result;

  logic               out_ready;
  logic               advance;
  logic [NKEYS-1:0]   new_press;
  press_t             press_next;

  // The result register can load when it is empty or being emptied this cycle.
  assign out_ready = !out_valid || !out_stall;
  // A poll moves forward, and the key levels update, only when it can land.
  assign advance   = poll_valid && out_ready;
  // The input register accepts when it is empty or its poll moves on.
  assign in_stall  = poll_valid && !advance;

  kdpd_level_bank u_bank (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .key_bits  (poll_bits),
    .new_press (new_press)
  );

  kdpd_press_select u_select (
    .new_press (new_press),
    .press     (press_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (!in_stall) begin
        poll_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= poll_valid;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      poll_bits <= key_bits;
    end
    if (advance) begin
      result <= press_next;
    end
  end

  assign press_valid = result.valid;
  assign press_index = result.index;
  assign press_label = result.label;

endmodule

>>> rtl/core/kdpd_checker.sv
`timescale 1ns / 1ps

module kdpd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [kdpd_pkg::KEY_BITS_W-1:0]  key_bits,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             press_valid,
  input logic [kdpd_pkg::INDEX_W-1:0]     press_index,
  input logic [kdpd_pkg::LABEL_W-1:0]     press_label
);
  import kdpd_pkg::*;

  // A stalled poll transaction stays put on the input side.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(key_bits))
    else $error("stalled poll changed");

  // A stalled result transaction stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(press_valid)
      && $stable(press_index) && $stable(press_label))
    else $error("stalled result changed");

  // A poll with no new press carries the idle index and a space.
  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !press_valid |-> press_index == '0 && press_label == LABEL_NONE)
    else $error("idle result has stray index or label");

  // A reported press always carries a printable key label.
  a_press_label: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_valid |-> press_label != LABEL_NONE)
    else $error("press reported with blank label");

  // The input stalls only behind a full, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output could drain");

endmodule

bind keypad_debounce_press_detect kdpd_checker u_kdpd_checker (.*);

>>> tb/tb_keypad_debounce_press_detect.sv
`timescale 1ns / 1ps

// Testbench for the keypad debounce and press detector.
//
// Every poll transaction that the block accepts is run through a local
// debounce model at the moment of acceptance. The model holds its own
// copy of the per-key level and produces the expected result transaction,
// which is queued. A monitor compares every result transaction that the
// block hands over against the oldest queued expectation, field by field.
//
// The stimulus is a set of named tests called in turn: directed polls at
// the edges of the behavior, random key chords (held, bounced, released)
// mixed with raw noise, a long output hold-off that fills the pipeline, a
// sender pause that drains everything, and a back-to-back end with no idle.
module tb_keypad_debounce_press_detect;
  import kdpd_pkg::*;

  localparam int HOLD_OFF_CYCLES = 40;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 4;

  // Labels in scan order, row by row: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D.
  localparam logic [LABEL_W-1:0] KEY_LABELS [NKEYS] = '{
    7'h31, 7'h32, 7'h33, 7'h41,
    7'h34, 7'h35, 7'h36, 7'h42,
    7'h37, 7'h38, 7'h39, 7'h43,
    7'h2A, 7'h30, 7'h23, 7'h44
  };

  // Directed polls. Each comment tells what the poll does to the key levels.
  localparam logic [KEY_BITS_W-1:0] DIRECTED_POLLS [23] = '{
    16'h0000,  // nothing pressed, nothing reported
    16'hFFFF,  // every key goes to maybe
    16'hFFFF,  // every key becomes held; the last one in scan order wins
    16'hFFFF,  // held steady, no new press
    16'h0000,  // every key falls back to maybe
    16'hFFFF,  // back to held from maybe, which counts as a new press
    16'h0000,
    16'h0000,  // all released again
    16'h0001,
    16'h0001,  // the first key alone
    16'h0000,
    16'h0000,
    16'h0101,
    16'h0101,  // two keys together, the later one is reported
    16'h0000,
    16'h0000,
    16'h5555,  // alternating patterns never let a key reach held
    16'hAAAA,
    16'h5555,
    16'h8000,
    16'h8000,  // the last key alone
    16'h0000,
    16'h0000
  };

  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic [LABEL_W-1:0] label;
  } poll_result_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [KEY_BITS_W-1:0] key_bits;
  logic                  out_valid;
  logic                  out_stall;
  logic                  press_valid;
  logic [INDEX_W-1:0]    press_index;
  logic [LABEL_W-1:0]    press_label;

  // Debounce level of every key as the model sees it.
  level_t       model_level [NKEYS];
  // Result transactions that the block still owes, oldest first.
  poll_result_t pending_presses [$];

  int error_count;
  int stuck_cycles;
  // Random idling on both channels; cleared for the final stretch.
  bit gaps_on;
  // Set by a test to make the receiver hold off for a long stretch.
  bit hold_off_req;

  keypad_debounce_press_detect u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .key_bits    (key_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .press_valid (press_valid),
    .press_index (press_index),
    .press_label (press_label)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances every key by one poll and returns the press that this poll
  // reports. A key that moves from maybe to held is a new press; scanning
  // in increasing index order lets the last such key overwrite earlier ones.
  function automatic poll_result_t debounce_poll(input logic [KEY_BITS_W-1:0] bits);
    poll_result_t res;
    res.valid = 1'b0;
    res.index = '0;
    res.label = LABEL_NONE;
    for (int k = 0; k < NKEYS; k++) begin
      if (bits[k]) begin
        if (model_level[k] == LVL_MAYBE) begin
          res.valid      = 1'b1;
          res.index      = INDEX_W'(k);
          res.label      = KEY_LABELS[k];
          model_level[k] = LVL_HELD;
        end else if (model_level[k] == LVL_RELEASED) begin
          model_level[k] = LVL_MAYBE;
        end
      end else begin
        if (model_level[k] == LVL_HELD) begin
          model_level[k] = LVL_MAYBE;
        end else if (model_level[k] == LVL_MAYBE) begin
          model_level[k] = LVL_RELEASED;
        end
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Offers one poll transaction and returns at the clock edge that accepts
  // it. The stall is looked at on the falling edge, where every signal is
  // settled, so acceptance never hinges on event order at the rising edge.
  // The expectation is queued before the edge; the result must still pass
  // the input and result registers, so the monitor never races it.
  task automatic send_poll(input logic [KEY_BITS_W-1:0] bits);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_bits <= bits;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    pending_presses.push_back(debounce_poll(bits));
    @(posedge clk);
  endtask

  // Stops offering and waits until every owed result has come back, plus a
  // further wait set by DRAIN_CYCLES so that a stray extra result would still be caught.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_presses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A random chord of one to three keys.
  function automatic logic [KEY_BITS_W-1:0] random_chord();
    logic [KEY_BITS_W-1:0] chord;
    chord = '0;
    repeat ($urandom_range(1, 3)) chord[$urandom_range(0, NKEYS - 1)] = 1'b1;
    return chord;
  endfunction

  // Presses a chord, holds it for a random number of polls with the odd
  // contact bounce, then lets go for a random number of polls.
  task automatic press_and_release(inout int sent);
    logic [KEY_BITS_W-1:0] chord;
    logic [KEY_BITS_W-1:0] bits;
    chord = random_chord();
    repeat ($urandom_range(1, 5)) begin
      bits = chord;
      if ($urandom_range(0, 7) == 0) bits[$urandom_range(0, NKEYS - 1)] ^= 1'b1;
      send_poll(bits);
      sent++;
    end
    repeat ($urandom_range(1, 3)) begin
      bits = '0;
      if ($urandom_range(0, 9) == 0) bits[$urandom_range(0, NKEYS - 1)] = 1'b1;
      send_poll(bits);
      sent++;
    end
  endtask

  task automatic test_directed_polls();
    foreach (DIRECTED_POLLS[i]) send_poll(DIRECTED_POLLS[i]);
    wait_drain();
  endtask

  // Mostly well-formed key activity; a fifth of the time raw noise, with
  // the all-ones pattern mixed in so every key can switch at once.
  task automatic test_random_presses(input int n_polls);
    int sent;
    sent = 0;
    while (sent < n_polls) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_poll(KEY_BITS_W'($urandom));
          sent++;
        end
        2: begin
          send_poll('1);
          sent++;
        end
        default: press_and_release(sent);
      endcase
    end
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while polls keep coming, so
  // both pipeline registers fill and the input stalls.
  task automatic test_output_hold_off();
    int sent;
    sent = 0;
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    while (sent < 40) press_and_release(sent);
    wait_drain();
    while (hold_off_req) @(posedge clk);
    gaps_on = 1'b1;
  endtask

  // The sender stops until every result is back, then carries on from
  // whatever key levels are left.
  task automatic test_sender_pause();
    int sent;
    sent = 0;
    while (sent < 10) press_and_release(sent);
    in_valid <= 1'b0;
    while (pending_presses.size() != 0) @(posedge clk);
    sent = 0;
    while (sent < 10) press_and_release(sent);
    wait_drain();
  endtask

  // Last stretch: no idling on either side, one transaction per cycle.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_presses(170);
  endtask

  // Receiver side: random stall bursts, or one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall    <= 1'b0;
        hold_off_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker. A result transaction is taken at the rising edge after
  // a falling edge that sees valid high and stall low; both are settled then.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_presses.size() == 0) begin
        $display("%0t: unexpected result: valid=%0d index=%0d label=%0d",
                 $time, press_valid, press_index, press_label);
        error_count++;
      end else begin
        poll_result_t want;
        want = pending_presses.pop_front();
        check_field("press_valid", int'(want.valid), int'(press_valid));
        check_field("press_index", int'(want.index), int'(press_index));
        check_field("press_label", int'(want.label), int'(press_label));
      end
    end
  end

  // Watchdog: the run is stuck if no transaction moves on either channel
  // for too long. The longest legal quiet stretch is the output hold-off.
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_keypad_debounce_press_detect: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    gaps_on      = 1'b1;
    hold_off_req = 1'b0;
    foreach (model_level[k]) model_level[k] = LVL_RELEASED;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    key_bits <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_polls();
    test_random_presses(1250);
    test_output_hold_off();
    test_sender_pause();
    test_back_to_back();

    if (error_count == 0) begin
      $display("tb_keypad_debounce_press_detect: done, clean");
    end else begin
      $display("tb_keypad_debounce_press_detect: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/kdpd_pkg.sv
rtl/core/kdpd_level_bank.sv
rtl/core/kdpd_press_select.sv
rtl/core/keypad_debounce_press_detect.sv
rtl/core/kdpd_checker.sv
tb/tb_keypad_debounce_press_detect.sv
